FILE: rtl/spm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the single pattern matcher.
// No dependencies; every other file of the block imports this package.
package spm_pkg;

  localparam int MAX_PATTERN_LENGTH_DEF = 64;
  localparam int OFFSET_WIDTH_DEF       = 32;

  localparam int ACTION_W = 2;
  localparam int SYMBOL_W = 8;
  localparam int INDEX_W  = 6;
  localparam int LENGTH_W = 7;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PATTERN = 2'd0,
    ACT_TEXT    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef logic [SYMBOL_W-1:0] symbol_t;

  typedef struct packed {
    logic    shift;
    logic    rotate;
    logic    capture;
    symbol_t sym;
  } cell_ctrl_t;

endpackage

FILE: rtl/spm_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the single pattern matcher: input, result and config.
// Depends on spm_pkg.
interface spm_in_if;
  import spm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  symbol_t             symbol;
  logic [INDEX_W-1:0]  pattern_index;

  modport source (output valid, output action, output symbol, output pattern_index,
                  input ready);
  modport sink   (input valid, input action, input symbol, input pattern_index,
                  output ready);
endinterface

interface spm_out_if #(
  parameter int OFFSET_WIDTH = spm_pkg::OFFSET_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [OFFSET_WIDTH-1:0] match_offset;
  logic                    offset_saturated;

  modport source (output valid, output match_offset, output offset_saturated,
                  input ready);
  modport sink   (input valid, input match_offset, input offset_saturated,
                  output ready);
endinterface

interface spm_cfg_if;
  import spm_pkg::*;

  logic                valid;
  logic                ready;
  logic [LENGTH_W-1:0] pattern_length;

  modport source (output valid, output pattern_length, input ready);
  modport sink   (input valid, input pattern_length, output ready);
endinterface

FILE: rtl/spm_cell.sv
`timescale 1ns / 1ps
// One matcher cell: a text window byte, a pattern byte and a compare flag.
// Depends on spm_pkg; instantiated in a row by single_pattern_matcher.
module spm_cell (
  input  logic             clk,
  input  spm_pkg::cell_ctrl_t ctrl,
  input  spm_pkg::symbol_t win_in,
  output spm_pkg::symbol_t win_out,
  input  spm_pkg::symbol_t pat_in,
  output spm_pkg::symbol_t pat_out,
  input  logic             wr_sel,
  input  logic             active,
  output logic             hit
);
  import spm_pkg::*;

  symbol_t win_r;
  symbol_t pat_r;
  logic    hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win_r <= win_in;
    end
    if (ctrl.rotate) begin
      pat_r <= pat_in;
    end else if (wr_sel) begin
      pat_r <= ctrl.sym;
    end
    if (ctrl.capture) begin
      hit_r <= !active || (pat_r == win_r);
    end
  end

  assign win_out = win_r;
  assign pat_out = pat_r;
  assign hit     = hit_r;

endmodule

FILE: rtl/single_pattern_matcher.sv
`timescale 1ns / 1ps
// Top level of the single pattern matcher: control, counters and the cell row.
// Depends on spm_pkg, spm_if and spm_cell.
//
//  channel   dir   payload                                  handshake
//  in_if     in    action, symbol, pattern_index            valid/ready
//  out_if    out   match_offset, offset_saturated           valid/ready
//  cfg_if    in    pattern_length                           valid/ready, ready always 1
//
// One item per cycle while in_if.ready is high; a matching text word's result passes through p0 and p1 to out_if.
// The row shifts one text byte per cycle while text is accepted and compares all cells in parallel.
// After a pattern_length write the pattern row rotates into place, one cell a cycle,
// with in_if.ready low until it is aligned.
// A stalled output holds the result; a pending match then holds the two stages behind it, then the input.
// Reset: synchronous, active low; clears control and counters, sets pattern_length to one.
module single_pattern_matcher #(
  parameter int MAX_PATTERN_LENGTH = spm_pkg::MAX_PATTERN_LENGTH_DEF,
  parameter int OFFSET_WIDTH       = spm_pkg::OFFSET_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spm_in_if.sink     in_if,
  spm_out_if.source  out_if,
  spm_cfg_if.sink    cfg_if
);
  import spm_pkg::*;

  localparam int AW = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
  localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int OW = OFFSET_WIDTH;
  localparam logic [OW-1:0] POS_MAX  = {OW{1'b1}};
  localparam logic [OW-1:0] MAX_EXT  = OW'(MAX_PATTERN_LENGTH);
  localparam logic [AW-1:0] AL_LAST  = AW'(MAX_PATTERN_LENGTH - 1);
  localparam logic [SW-1:0] MAX_SW   = SW'(MAX_PATTERN_LENGTH);

  action_t act;
  logic    in_acc, is_text, is_pat, is_rst;

  logic [LENGTH_W-1:0] len_r, len_nxt;
  logic [OW-1:0]       len_ext, act_len;
  logic [AW-1:0]       al_r, al_nxt, al_target;
  logic                aligned;

  logic [SW-1:0] wr_sum, wr_addr;
  logic          wr_ok;

  logic [OW-1:0] pos_r, pos_nxt;
  logic          sat_r, sat_nxt;
  logic [OW:0]   pos_inc;
  logic          elig;
  logic [OW-1:0] offset;

  logic          p0_valid_r, p0_valid_nxt, p0_elig_r, p0_sat_r;
  logic [OW-1:0] p0_off_r;
  logic          p1_valid_r, p1_valid_nxt, p1_elig_r, p1_sat_r;
  logic [OW-1:0] p1_off_r;
  logic          out_valid_r, out_valid_nxt, out_sat_r;
  logic [OW-1:0] out_off_r;

  logic p0_go, p1_go, p1_free, out_free, hit;

  cell_ctrl_t                  ctrl;
  symbol_t                     win_q [MAX_PATTERN_LENGTH];
  symbol_t                     pat_q [MAX_PATTERN_LENGTH];
  logic [MAX_PATTERN_LENGTH-1:0] cell_hit;

  assign act     = action_t'(in_if.action);
  assign in_acc  = in_if.valid && in_if.ready;
  assign is_text = in_acc && (act == ACT_TEXT);
  assign is_pat  = in_acc && (act == ACT_PATTERN);
  assign is_rst  = in_acc && (act == ACT_RESTART);

  // length and pattern alignment
  assign cfg_if.ready = 1'b1;
  assign len_nxt = (cfg_if.valid && cfg_if.ready) ? cfg_if.pattern_length : len_r;
  assign len_ext = OW'(len_r);
  assign act_len = (len_ext > MAX_EXT) ? MAX_EXT : len_ext;
  assign al_target = (act_len == '0) ? al_r : AW'(MAX_EXT - act_len);
  assign aligned   = (al_r == al_target);
  assign al_nxt    = aligned ? al_r : ((al_r == '0) ? AL_LAST : al_r - 1'b1);

  assign wr_sum  = SW'(in_if.pattern_index) + SW'(al_r);
  assign wr_addr = (wr_sum >= MAX_SW) ? wr_sum - MAX_SW : wr_sum;
  assign wr_ok   = is_pat && (SW'(in_if.pattern_index) < MAX_SW);

  // text position
  assign pos_inc = {1'b0, pos_r} + (OW+1)'(1);
  assign elig    = (act_len != '0) && (pos_inc >= {1'b0, act_len});
  assign offset  = OW'(pos_inc - {1'b0, act_len});

  always_comb begin
    pos_nxt = pos_r;
    sat_nxt = sat_r;
    if (is_rst) begin
      pos_nxt = '0;
      sat_nxt = 1'b0;
    end else if (is_text) begin
      if (pos_r == POS_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        pos_nxt = OW'(pos_inc);
      end
    end
  end

  // pipeline handshake
  assign hit      = p1_valid_r && p1_elig_r && (&cell_hit);
  assign out_free = !out_valid_r || out_if.ready;
  assign p1_go    = p1_valid_r && (!hit || out_free);
  assign p1_free  = !p1_valid_r || p1_go;
  assign p0_go    = p0_valid_r && p1_free;
  assign in_if.ready = aligned && (!p0_valid_r || p1_free);

  assign p0_valid_nxt  = is_text || (p0_valid_r && !p0_go);
  assign p1_valid_nxt  = p0_go || (p1_valid_r && !p1_go);
  assign out_valid_nxt = (p1_go && hit) || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LENGTH_RESET;
      al_r        <= AL_LAST;
      pos_r       <= '0;
      sat_r       <= 1'b0;
      p0_valid_r  <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      al_r        <= al_nxt;
      pos_r       <= pos_nxt;
      sat_r       <= sat_nxt;
      p0_valid_r  <= p0_valid_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_text) begin
      p0_elig_r <= elig;
      p0_off_r  <= offset;
      p0_sat_r  <= sat_r;
    end
    if (p0_go) begin
      p1_elig_r <= p0_elig_r;
      p1_off_r  <= p0_off_r;
      p1_sat_r  <= p0_sat_r;
    end
    if (p1_go && hit) begin
      out_off_r <= p1_off_r;
      out_sat_r <= p1_sat_r;
    end
  end

  // cell row
  assign ctrl.shift   = is_text;
  assign ctrl.rotate  = !aligned;
  assign ctrl.capture = p0_go;
  assign ctrl.sym     = in_if.symbol;

  for (genvar j = 0; j < MAX_PATTERN_LENGTH; j++) begin : g_cell
    localparam int NXT = (j + 1) % MAX_PATTERN_LENGTH;
    symbol_t win_in;
    logic    wr_sel, active;

    if (j == MAX_PATTERN_LENGTH - 1) begin : g_top
      assign win_in = in_if.symbol;
    end else begin : g_mid
      assign win_in = win_q[j+1];
    end
    assign wr_sel = wr_ok && (wr_addr == SW'(j));
    assign active = (AW'(j) >= al_r);

    spm_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .win_in  (win_in),
      .win_out (win_q[j]),
      .pat_in  (pat_q[NXT]),
      .pat_out (pat_q[j]),
      .wr_sel  (wr_sel),
      .active  (active),
      .hit     (cell_hit[j])
    );
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.match_offset     = out_off_r;
  assign out_if.offset_saturated = out_sat_r;

endmodule

FILE: rtl/spm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the single pattern matcher, bound to its top level.
// Depends on spm_pkg and single_pattern_matcher.
module spm_checker #(
  parameter int OFFSET_WIDTH = spm_pkg::OFFSET_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [spm_pkg::ACTION_W-1:0] in_action,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [OFFSET_WIDTH-1:0]      out_offset,
  input logic                         out_sat
);
  import spm_pkg::*;

  logic [31:0] credit_r, credit_nxt;
  logic        ovf_r, ovf_nxt;
  logic        text_acc, out_acc;

  assign text_acc = in_valid && in_ready && (in_action == ACT_TEXT);
  assign out_acc  = out_valid && out_ready;

  always_comb begin
    credit_nxt = credit_r;
    ovf_nxt    = ovf_r;
    if (!ovf_r) begin
      if (text_acc && !out_acc) begin
        if (credit_r == '1) begin
          ovf_nxt = 1'b1;
        end else begin
          credit_nxt = credit_r + 1'b1;
        end
      end else if (!text_acc && out_acc && credit_r != '0) begin
        credit_nxt = credit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_offset) && $stable(out_sat))
    else $error("stalled result changed");

  a_result_has_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (credit_r != '0) || ovf_r)
    else $error("more results than text words");

endmodule

bind single_pattern_matcher spm_checker #(
  .OFFSET_WIDTH (OFFSET_WIDTH)
) u_spm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_action  (in_if.action),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_offset (out_if.match_offset),
  .out_sat    (out_if.offset_saturated)
);
